// ===== hw/rtl/generational_handle_allocator_unit_assert.svh =====
// Assertion macros for the allocator top module. They expect clk and arst_n in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH

`define GHA_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("allocator invariant violated");

`define GHA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator same-cycle check failed");

`define GHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator next-cycle check failed");

`endif

// ===== hw/rtl/gha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int ID_W      = 8;
	localparam int CNT_W     = ID_W + 1;
	localparam int GEN_W     = 16;
	localparam int MASK_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE  = 3'd0,
		OP_DESTROY = 3'd1,
		OP_GET     = 3'd2,
		OP_SET     = 3'd3,
		OP_ALIVE   = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [GEN_W-1:0]  hgen;
		logic [MASK_W-1:0] mask;
		logic [GEN_W-1:0]  gen_rd;
		logic [MASK_W-1:0] mask_rd;
	} s1_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] issued;
		logic [CNT_W-1:0] free;
		logic [ID_W-1:0]  top_id;
		logic [GEN_W-1:0] top_gen;
	} alloc_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_id;
		logic [GEN_W-1:0]    out_gen;
		logic [MASK_W-1:0]   mask_out;
		logic                alive;
	} result_t;

	typedef struct packed {
		logic              gen_we;
		logic [ID_W-1:0]   gen_wa;
		logic [GEN_W-1:0]  gen_wd;
		logic              mask_we;
		logic [ID_W-1:0]   mask_wa;
		logic [MASK_W-1:0] mask_wd;
		logic              push;
		logic              pop;
		logic              fresh;
		logic              clr;
	} update_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gha_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gha_exec
	import gha_pkg::*;
(
	input  s1_item_t     item,
	input  alloc_state_t st,
	output result_t      res,
	output update_t      upd
);

	logic issued;

	always_comb begin
		issued = {1'b0, item.id} < st.issued;
		res = '0;
		upd = '0;
		res.status = ST_OK;
		case (item.op)
			OP_CREATE: begin
				if (st.free != '0) begin
					upd.pop     = 1'b1;
					upd.mask_we = 1'b1;
					upd.mask_wa = st.top_id;
					res.out_id  = st.top_id;
					res.out_gen = st.top_gen;
				end else if (st.issued < CNT_W'(MAX_SLOTS)) begin
					upd.fresh   = 1'b1;
					upd.gen_we  = 1'b1;
					upd.gen_wa  = st.issued[ID_W-1:0];
					upd.mask_we = 1'b1;
					upd.mask_wa = st.issued[ID_W-1:0];
					res.out_id  = st.issued[ID_W-1:0];
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_DESTROY: begin
				if (!issued || item.gen_rd != item.hgen || st.free >= CNT_W'(MAX_SLOTS)) begin
					res.status = ST_BAD;
				end else begin
					upd.gen_we  = 1'b1;
					upd.gen_wa  = item.id;
					upd.gen_wd  = item.gen_rd + GEN_W'(1);
					upd.mask_we = 1'b1;
					upd.mask_wa = item.id;
					upd.push    = 1'b1;
				end
			end
			OP_GET: begin
				if (!issued) begin
					res.status = ST_BAD;
				end else begin
					res.mask_out = item.mask_rd;
				end
			end
			OP_SET: begin
				if (!issued) begin
					res.status = ST_BAD;
				end else begin
					upd.mask_we = 1'b1;
					upd.mask_wa = item.id;
					upd.mask_wd = item.mask;
				end
			end
			OP_ALIVE: begin
				if (!issued) begin
					res.status = ST_BAD;
				end else begin
					res.alive = (item.gen_rd == item.hgen);
				end
			end
			OP_CLEAR: begin
				upd.clr = 1'b1;
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generational handle allocator.
// Input channel (in_valid/in_ready) carries one operation per item: op, slot_id,
// handle_gen and mask_in. Output channel (out_valid/out_ready) returns exactly one
// result item per input item, in order: status, out_id, out_gen, mask_out, alive.
// An accepted item is captured into a stage register together with its generation
// and mask reads; when the output register is free or being emptied, the operation
// executes, the tables are updated and the result lands in the output register, which
// raises out_valid. One item is accepted every cycle while the output side keeps up.
// The top of the free stack, the entry below it and the top's generation are kept
// in registers, so a create can pop and report its generation without a dependent
// memory read; back-to-back items see earlier writes through forwarding.
// Reset empties the pipeline and clears the issued and free counters; the tables
// need no clearing since only entries below those counters are ever used.
// When the receiver stalls, the output register holds its item, the stage register
// holds the next one, and in_ready falls until the output item is taken.
`include "generational_handle_allocator_unit_assert.svh"

module generational_handle_allocator_unit
	import gha_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [ID_W-1:0]     slot_id,
	input  wire logic [GEN_W-1:0]    handle_gen,
	input  wire logic [MASK_W-1:0]   mask_in,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          out_id,
	output logic [GEN_W-1:0]         out_gen,
	output logic [MASK_W-1:0]        mask_out,
	output logic                     alive
);

	logic              [GEN_W-1:0]  gen_mem   [MAX_SLOTS];
	logic              [MASK_W-1:0] mask_mem  [MAX_SLOTS];
	logic              [ID_W-1:0]   stack_mem [MAX_SLOTS];

	logic                           valid_s1;
	s1_item_t                       item_s1;
	logic                           out_valid_q;
	result_t                        res_q;
	logic              [CNT_W-1:0]  issued_q;
	logic              [CNT_W-1:0]  free_q;
	logic              [ID_W-1:0]   top_q;
	logic              [ID_W-1:0]   below_q;
	logic              [GEN_W-1:0]  top_gen_q;

	alloc_state_t                   st;
	result_t                        res;
	update_t                        upd;
	logic                           advance;
	logic                           accept;
	logic              [CNT_W-1:0]  below_addr;

	assign advance    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance;
	assign accept     = in_valid && in_ready;
	assign below_addr = free_q - CNT_W'(3);

	assign st.issued  = issued_q;
	assign st.free    = free_q;
	assign st.top_id  = top_q;
	assign st.top_gen = top_gen_q;

	gha_exec u_exec (
		.item (item_s1),
		.st   (st),
		.res  (res),
		.upd  (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			issued_q    <= '0;
			free_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (upd.clr) begin
					issued_q <= '0;
					free_q   <= '0;
				end else begin
					if (upd.fresh) begin
						issued_q <= issued_q + CNT_W'(1);
					end
					if (upd.push) begin
						free_q <= free_q + CNT_W'(1);
					end else if (upd.pop) begin
						free_q <= free_q - CNT_W'(1);
					end
				end
			end
		end
	end

	// Stage payload, output payload and the cached top of the free stack.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= op;
			item_s1.id   <= slot_id;
			item_s1.hgen <= handle_gen;
			item_s1.mask <= mask_in;
			if (advance && upd.gen_we && upd.gen_wa == slot_id) begin
				item_s1.gen_rd <= upd.gen_wd;
			end else begin
				item_s1.gen_rd <= gen_mem[slot_id];
			end
			if (advance && upd.mask_we && upd.mask_wa == slot_id) begin
				item_s1.mask_rd <= upd.mask_wd;
			end else begin
				item_s1.mask_rd <= mask_mem[slot_id];
			end
		end
		if (advance) begin
			res_q <= res;
			if (upd.push) begin
				top_q     <= item_s1.id;
				below_q   <= top_q;
				top_gen_q <= upd.gen_wd;
			end else if (upd.pop) begin
				top_q     <= below_q;
				below_q   <= stack_mem[below_addr[ID_W-1:0]];
				top_gen_q <= gen_mem[below_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && upd.gen_we) begin
			gen_mem[upd.gen_wa] <= upd.gen_wd;
		end
		if (advance && upd.mask_we) begin
			mask_mem[upd.mask_wa] <= upd.mask_wd;
		end
		if (advance && upd.push) begin
			stack_mem[free_q[ID_W-1:0]] <= item_s1.id;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign out_id    = res_q.out_id;
	assign out_gen   = res_q.out_gen;
	assign mask_out  = res_q.mask_out;
	assign alive     = res_q.alive;

	`GHA_ASSERT_ALWAYS(a_free_bound, free_q <= CNT_W'(MAX_SLOTS))
	`GHA_ASSERT_ALWAYS(a_issued_bound, issued_q <= CNT_W'(MAX_SLOTS))
	`GHA_ASSERT_IMPL(a_pop_nonempty, advance && upd.pop, free_q != '0)
	`GHA_ASSERT_NEXT(a_result_loaded, advance, out_valid_q)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gha_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int MIX_ITEMS = 55;

	typedef struct packed {
		logic [OP_W-1:0]   code;
		logic [ID_W-1:0]   sid;
		logic [GEN_W-1:0]  hg;
		logic [MASK_W-1:0] mk;
	} req_t;

	typedef struct packed {
		req_t    rq;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [ID_W-1:0]     slot_id;
	logic [GEN_W-1:0]    handle_gen;
	logic [MASK_W-1:0]   mask_in;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_id;
	logic [GEN_W-1:0]    out_gen;
	logic [MASK_W-1:0]   mask_out;
	logic                alive;

	// Shadow copy of the allocator state.
	int unsigned       n_issued;
	int unsigned       n_free;
	logic [ID_W-1:0]   free_ids [MAX_SLOTS];
	logic [GEN_W-1:0]  gens [MAX_SLOTS];
	logic [MASK_W-1:0] masks [MAX_SLOTS];

	result_t  pending_results [$];
	dir_row_t dir_rows [$];

	int in_idle_pct;
	int out_idle_pct;
	int mismatches;
	int results_checked;
	int full_answers;
	int rejected_answers;
	int op_count [8];
	int quiet_cycles;

	generational_handle_allocator_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.slot_id    (slot_id),
		.handle_gen (handle_gen),
		.mask_in    (mask_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_id     (out_id),
		.out_gen    (out_gen),
		.mask_out   (mask_out),
		.alive      (alive)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic result_t alloc_apply(input req_t rq);
		result_t r;
		logic [ID_W-1:0] nid;
		bit known;
		r = '0;
		known = (rq.sid < n_issued);
		case (rq.code)
		OP_CREATE: begin
			if (n_free > 0) begin
				n_free--;
				nid = free_ids[n_free];
				masks[nid] = '0;
				r.out_id = nid;
				r.out_gen = gens[nid];
			end else if (n_issued < MAX_SLOTS) begin
				nid = ID_W'(n_issued);
				n_issued++;
				gens[nid] = '0;
				masks[nid] = '0;
				r.out_id = nid;
			end else begin
				r.status = ST_FULL;
			end
		end
		OP_DESTROY: begin
			if (!known || gens[rq.sid] != rq.hg || n_free >= MAX_SLOTS) begin
				r.status = ST_BAD;
			end else begin
				gens[rq.sid] = gens[rq.sid] + 1'b1;
				masks[rq.sid] = '0;
				free_ids[n_free] = rq.sid;
				n_free++;
			end
		end
		OP_GET: begin
			if (!known) r.status = ST_BAD;
			else r.mask_out = masks[rq.sid];
		end
		OP_SET: begin
			if (!known) r.status = ST_BAD;
			else masks[rq.sid] = rq.mk;
		end
		OP_ALIVE: begin
			if (!known) r.status = ST_BAD;
			else r.alive = (gens[rq.sid] == rq.hg);
		end
		OP_CLEAR: begin
			n_issued = 0;
			n_free = 0;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	function automatic req_t make_req(input logic [OP_W-1:0] code, input logic [ID_W-1:0] sid,
			input logic [GEN_W-1:0] hg, input logic [MASK_W-1:0] mk);
		req_t rq;
		rq.code = code;
		rq.sid = sid;
		rq.hg = hg;
		rq.mk = mk;
		return rq;
	endfunction

	// Mostly handles that the allocator has issued, with some forged or random ones.
	function automatic req_t random_req();
		req_t rq;
		int unsigned pick;
		rq = make_req(OP_CREATE, ID_W'($urandom), GEN_W'($urandom), $urandom);
		pick = $urandom_range(99);
		if (pick < 24) begin
			rq.code = OP_CREATE;
		end else if (pick < 86) begin
			if (pick < 44) rq.code = OP_DESTROY;
			else if (pick < 56) rq.code = OP_GET;
			else if (pick < 70) rq.code = OP_SET;
			else rq.code = OP_ALIVE;
			if (n_issued > 0 && $urandom_range(9) < 8) begin
				rq.sid = ID_W'($urandom_range(n_issued - 1));
				if ($urandom_range(9) < 7) rq.hg = gens[rq.sid];
			end
		end else if (pick < 88) begin
			rq.code = OP_CLEAR;
		end else begin
			rq.code = OP_W'($urandom);
		end
		return rq;
	endfunction

	task automatic issue(input req_t rq, input bit typed, input result_t want);
		int gap;
		result_t predicted;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= rq.code;
		slot_id <= rq.sid;
		handle_gen <= rq.hg;
		mask_in <= rq.mk;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = alloc_apply(rq);
		pending_results = {pending_results, (typed ? want : predicted)};
		op_count[rq.code]++;
	endtask

	task automatic add_row(input logic [OP_W-1:0] code, input logic [ID_W-1:0] sid,
			input logic [GEN_W-1:0] hg, input logic [MASK_W-1:0] mk, input logic typed,
			input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] oid,
			input logic [GEN_W-1:0] og, input logic [MASK_W-1:0] om, input logic al);
		dir_row_t row;
		row.rq = make_req(code, sid, hg, mk);
		row.typed = typed;
		row.want = '{st, oid, og, om, al};
		dir_rows = {dir_rows, row};
	endtask

	task automatic check_field(input string name, input logic [MASK_W-1:0] want,
			input logic [MASK_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (status == ST_FULL) full_answers++;
			if (status == ST_BAD) rejected_answers++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d id %0d gen %0d",
					$time, status, out_id, out_gen);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("out_id", want.out_id, out_id);
				check_field("out_gen", want.out_gen, out_gen);
				check_field("mask_out", want.mask_out, mask_out);
				check_field("alive", want.alive, alive);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pass_idle_in [3];
		int pass_idle_out [3];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_CREATE;
		slot_id <= '0;
		handle_gen <= '0;
		mask_in <= '0;
		out_ready <= 1'b0;
		in_idle_pct = 12;
		out_idle_pct = 60;
		mismatches = 0;
		results_checked = 0;
		full_answers = 0;
		rejected_answers = 0;
		quiet_cycles = 0;
		n_issued = 0;
		n_free = 0;
		foreach (op_count[i]) op_count[i] = 0;
		pass_idle_in = '{12, 60, 0};
		pass_idle_out = '{60, 12, 0};

		add_row(OP_GET, 8'd0, 16'd0, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_ALIVE, 8'd0, 16'd0, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_DESTROY, 8'd0, 16'd0, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_SET, 8'd0, 16'd0, 32'hFFFF_FFFF, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_CREATE, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_CREATE, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 8'd1, 16'd0, 32'd0,
			1'b0);
		add_row(OP_SET, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_GET, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
		add_row(OP_GET, 8'd1, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_ALIVE, 8'd1, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b1);
		add_row(OP_ALIVE, 8'd1, 16'hFFFF, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_ALIVE, 8'd255, 16'd0, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_DESTROY, 8'd0, 16'hFFFF, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_DESTROY, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_GET, 8'd0, 16'h1234, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_SET, 8'd0, 16'h0, 32'hA5A5_5A5A, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_ALIVE, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_CREATE, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd1, 32'd0, 1'b0);
		add_row(OP_GET, 8'd0, 16'd0, 32'd0, 1'b0, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_SPARE_6, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0,
			1'b0);
		add_row(OP_SPARE_7, 8'd1, 16'd1, 32'h5A5A_A5A5, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_DESTROY, 8'd1, 16'd0, 32'h0F0F_0F0F, 1'b0, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_CLEAR, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_GET, 8'd1, 16'd0, 32'd0, 1'b1, ST_BAD, 8'd0, 16'd0, 32'd0, 1'b0);
		add_row(OP_CREATE, 8'd0, 16'd0, 32'd0, 1'b1, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < 3; p++) begin
			in_idle_pct = pass_idle_in[p];
			out_idle_pct = pass_idle_out[p];
			if (p == 2) begin
				// Issue every slot and then one create more, which finds the allocator full.
				issue(make_req(OP_CLEAR, ID_W'($urandom), GEN_W'($urandom), $urandom), 1'b0,
					'0);
				for (int i = 0; i <= MAX_SLOTS; i++)
					issue(make_req(OP_CREATE, ID_W'($urandom), GEN_W'($urandom), $urandom),
						1'b0, '0);
			end
			for (int i = 0; i < MIX_ITEMS; i++) issue(random_req(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d results from %0d creates, %0d destroys, %0d mask reads,",
			results_checked, op_count[OP_CREATE], op_count[OP_DESTROY], op_count[OP_GET]);
		$display("%0d mask writes, %0d liveness queries and %0d clears; %0d full, %0d rejected.",
			op_count[OP_SET], op_count[OP_ALIVE], op_count[OP_CLEAR], full_answers,
			rejected_answers);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_exec.sv
hw/rtl/generational_handle_allocator_unit.sv
tb/sv/testbench.sv
